[rtl/core/fptd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fptd_pkg
// Shared codes and widths for the fixed-priority task dispatcher.
// ----------------------------------------------------------------------------
package fptd_pkg;

  // Width of the global tick and idle counters
  localparam int CNT_W = 32;

  // Request opcodes
  typedef logic [0:0] opcode_t;
  localparam opcode_t OP_TICK   = 1'b0;
  localparam opcode_t OP_CREATE = 1'b1;

  // Per-slot status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_DELETED = 2'd0;
  localparam status_t ST_READY   = 2'd1;
  localparam status_t ST_PENDING = 2'd2;
  localparam status_t ST_WAITING = 2'd3;

endpackage

`default_nettype wire

[rtl/core/fixed_priority_task_dispatcher.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a create request goes from acceptance to the done state; a tick
//   request sweeps every slot, selects, runs the winner if any, then is done.
// Flow: one request at a time; the tick cost is set by the sweep of every
//   slot record through the single read and write port of the record RAM.
// Reset: synchronous; all slots deleted, running slot idle, counters zero. The
//   record RAM is not cleared, a slot's record is written when it is created.
// ----------------------------------------------------------------------------
// fixed_priority_task_dispatcher
// Tick-driven periodic task dispatcher, lower slot index = higher priority.
// ----------------------------------------------------------------------------
module fixed_priority_task_dispatcher #(
  parameter int NUM_TASKS  = 8,
  parameter int TIME_WIDTH = 16
) (
  input  wire logic                                                 clk,
  input  wire logic                                                 rst,
  input  wire logic                                                 in_valid,
  output logic                                                      in_stall,
  input  wire fptd_pkg::opcode_t                                    opcode,
  input  wire logic [((NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1)-1:0] task_slot,
  input  wire logic [TIME_WIDTH-1:0]                                exec_time,
  input  wire logic [TIME_WIDTH-1:0]                                release_period,
  input  wire logic [TIME_WIDTH-1:0]                                first_offset,
  output logic                                                      out_valid,
  input  wire logic                                                 out_stall,
  output logic [$clog2(NUM_TASKS + 1)-1:0]                          running_task,
  output logic                                                      start_event,
  output logic [TIME_WIDTH-1:0]                                     start_job,
  output logic                                                      finish_event,
  output logic [((NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1)-1:0]      finish_task,
  output logic [TIME_WIDTH-1:0]                                     finish_job,
  output logic [fptd_pkg::CNT_W-1:0]                                tick_time,
  output logic [fptd_pkg::CNT_W-1:0]                                idle_ticks
);

  import fptd_pkg::*;

  localparam int SLOT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int RUN_W  = $clog2(NUM_TASKS + 1);
  localparam logic [RUN_W-1:0] IDLE_SLOT = RUN_W'(NUM_TASKS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_SEL   = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] exec;
    logic [TIME_WIDTH-1:0] period;
    logic [TIME_WIDTH-1:0] work;
    logic [TIME_WIDTH-1:0] countdown;
    logic [TIME_WIDTH-1:0] count;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  logic [2:0]             state;
  status_t                status [NUM_TASKS];
  logic [RUN_W-1:0]       current_slot;
  logic [CNT_W-1:0]       tick_counter;
  logic [CNT_W-1:0]       idle_counter;
  logic [RUN_W-1:0]       sweep_idx;
  logic                   proc_valid;
  logic [SLOT_W-1:0]      proc_idx;
  logic                   cur_zero;
  logic [SLOT_W-1:0]      pick_r;
  logic [RUN_W-1:0]       prev_cur;
  logic                   res_start;
  logic [TIME_WIDTH-1:0]  res_start_job;
  logic                   res_fin;
  logic [SLOT_W-1:0]      res_fin_task;
  logic [TIME_WIDTH-1:0]  res_fin_job;

  logic                   accept;
  logic                   slot_ok;
  logic                   offs_zero;
  rec_t                   create_rec;
  rec_t                   rd_rec;
  rec_t                   sweep_rec;
  rec_t                   exec_rec;
  logic                   proc_live;
  logic                   rel;
  logic [TIME_WIDTH-1:0]  cd_dec;
  logic [TIME_WIDTH-1:0]  work_dec;
  logic                   pick_found;
  logic [SLOT_W-1:0]      pick;
  logic [RUN_W-1:0]       cur_eff;

  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [REC_W-1:0]       ram_wdata;
  logic [SLOT_W-1:0]      ram_raddr;
  logic [REC_W-1:0]       ram_rdata;

  fptd_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_TASKS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_ok   = RUN_W'(task_slot) < IDLE_SLOT;
  assign offs_zero = (first_offset == '0);
  assign rd_rec    = rec_t'(ram_rdata);

  always_comb begin
    create_rec.exec      = exec_time;
    create_rec.period    = release_period;
    create_rec.work      = offs_zero ? exec_time : '0;
    create_rec.countdown = offs_zero ? release_period : first_offset;
    create_rec.count     = offs_zero ? TIME_WIDTH'(1) : '0;
  end

  // Release step for the record coming out of the sweep read
  assign proc_live = (status[proc_idx] != ST_DELETED);
  assign cd_dec    = rd_rec.countdown - TIME_WIDTH'(1);
  assign rel       = (cd_dec == '0);

  always_comb begin
    sweep_rec = rd_rec;
    if (rel) begin
      sweep_rec.work      = rd_rec.exec;
      sweep_rec.countdown = rd_rec.period;
      sweep_rec.count     = rd_rec.count + TIME_WIDTH'(1);
    end else begin
      sweep_rec.countdown = cd_dec;
    end
  end

  assign work_dec = rd_rec.work - TIME_WIDTH'(1);

  always_comb begin
    exec_rec      = rd_rec;
    exec_rec.work = work_dec;
  end

  // First ready or pending slot wins
  always_comb begin
    pick_found = 1'b0;
    pick       = '0;
    for (int i = NUM_TASKS - 1; i >= 0; i--) begin
      if (status[i] == ST_READY || status[i] == ST_PENDING) begin
        pick_found = 1'b1;
        pick       = SLOT_W'(i);
      end
    end
  end

  assign cur_eff = (current_slot != IDLE_SLOT && cur_zero) ? IDLE_SLOT : current_slot;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      S_IDLE: begin
        ram_we    = accept && (opcode == OP_CREATE) && slot_ok;
        ram_waddr = task_slot;
        ram_wdata = create_rec;
      end
      S_SWEEP: begin
        // Read slot k+1 while writing back slot k: never the same entry
        ram_we    = proc_valid && proc_live;
        ram_waddr = proc_idx;
        ram_wdata = sweep_rec;
        if (sweep_idx < IDLE_SLOT) begin
          ram_raddr = sweep_idx[SLOT_W-1:0];
        end
      end
      S_SEL: begin
        ram_raddr = pick;
      end
      S_EXEC: begin
        ram_we    = 1'b1;
        ram_waddr = pick_r;
        ram_wdata = exec_rec;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      current_slot <= IDLE_SLOT;
      tick_counter <= '0;
      idle_counter <= '0;
      out_valid    <= 1'b0;
      proc_valid   <= 1'b0;
      sweep_idx    <= '0;
      cur_zero     <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        status[i] <= ST_DELETED;
      end
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_start     <= 1'b0;
            res_start_job <= '0;
            res_fin       <= 1'b0;
            res_fin_task  <= '0;
            res_fin_job   <= '0;
            if (opcode == OP_CREATE) begin
              if (slot_ok) begin
                status[task_slot] <= offs_zero ? ST_READY : ST_WAITING;
              end
              state <= S_DONE;
            end else begin
              tick_counter <= tick_counter + CNT_W'(1);
              sweep_idx    <= '0;
              proc_valid   <= 1'b0;
              cur_zero     <= 1'b0;
              state        <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          if (proc_valid && proc_live) begin
            if (rel) begin
              status[proc_idx] <= ST_READY;
            end
            if (RUN_W'(proc_idx) == current_slot) begin
              cur_zero <= (sweep_rec.work == '0);
            end
          end
          if (sweep_idx < IDLE_SLOT) begin
            proc_valid <= 1'b1;
            proc_idx   <= sweep_idx[SLOT_W-1:0];
            sweep_idx  <= sweep_idx + RUN_W'(1);
          end else begin
            proc_valid <= 1'b0;
            state      <= S_SEL;
          end
        end
        S_SEL: begin
          if (pick_found) begin
            // Demote ready slots below the winner
            for (int i = 0; i < NUM_TASKS; i++) begin
              if (SLOT_W'(i) > pick && status[i] == ST_READY) begin
                status[i] <= ST_PENDING;
              end
            end
            status[pick] <= ST_READY;
            pick_r       <= pick;
            prev_cur     <= cur_eff;
            state        <= S_EXEC;
          end else begin
            current_slot <= IDLE_SLOT;
            idle_counter <= idle_counter + CNT_W'(1);
            state        <= S_DONE;
          end
        end
        S_EXEC: begin
          if (RUN_W'(pick_r) != prev_cur && rd_rec.work == rd_rec.exec) begin
            res_start     <= 1'b1;
            res_start_job <= rd_rec.count;
          end
          if (work_dec == '0) begin
            status[pick_r] <= ST_WAITING;
            res_fin        <= 1'b1;
            res_fin_task   <= pick_r;
            res_fin_job    <= rd_rec.count;
          end
          current_slot <= RUN_W'(pick_r);
          state        <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the output register frees up
          if (!out_valid || !out_stall) begin
            running_task <= current_slot;
            start_event  <= res_start;
            start_job    <= res_start_job;
            finish_event <= res_fin;
            finish_task  <= res_fin_task;
            finish_job   <= res_fin_job;
            tick_time    <= tick_counter;
            idle_ticks   <= idle_counter;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SWEEP || state == S_DONE))
    else $error("accepted request did not start processing");

  a_running_slot_created: assert property (@(posedge clk) disable iff (rst)
    (current_slot < IDLE_SLOT) |-> (status[current_slot[SLOT_W-1:0]] != ST_DELETED))
    else $error("running slot points at a deleted slot");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result presented outside the done state");

  a_tick_count_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    !(accept && opcode == OP_TICK) |=> $stable(tick_counter))
    else $error("tick counter moved without a tick request");
`endif

endmodule

`default_nettype wire

[rtl/core/fptd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fptd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fptd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[tb/fptd_dispatch_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fptd_dispatch_checker
// Watches both channels of the task dispatcher. It keeps its own copy of the
// slot table and counters, works out the result of every accepted request,
// and compares each accepted result field by field against the oldest one.
// ----------------------------------------------------------------------------
module fptd_dispatch_checker #(
  parameter int NUM_TASKS  = 8,
  parameter int TIME_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  fptd_pkg::opcode_t             opcode,
  input  logic [$clog2(NUM_TASKS)-1:0]  task_slot,
  input  logic [TIME_WIDTH-1:0]         exec_time,
  input  logic [TIME_WIDTH-1:0]         release_period,
  input  logic [TIME_WIDTH-1:0]         first_offset,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [$clog2(NUM_TASKS+1)-1:0] running_task,
  input  logic                          start_event,
  input  logic [TIME_WIDTH-1:0]         start_job,
  input  logic                          finish_event,
  input  logic [$clog2(NUM_TASKS)-1:0]  finish_task,
  input  logic [TIME_WIDTH-1:0]         finish_job,
  input  logic [fptd_pkg::CNT_W-1:0]    tick_time,
  input  logic [fptd_pkg::CNT_W-1:0]    idle_ticks,
  output int                            fail_count,
  output int                            waiting_results,
  output int                            results_seen,
  output int                            starts_seen,
  output int                            finishes_seen
);
  import fptd_pkg::*;

  localparam int SLOT_W = $clog2(NUM_TASKS);
  localparam int RUN_W  = $clog2(NUM_TASKS + 1);

  typedef struct {
    logic [RUN_W-1:0]      running;
    logic                  start_ev;
    logic [TIME_WIDTH-1:0] start_job;
    logic                  fin_ev;
    logic [SLOT_W-1:0]     fin_task;
    logic [TIME_WIDTH-1:0] fin_job;
    logic [CNT_W-1:0]      ticks;
    logic [CNT_W-1:0]      idles;
  } dispatch_result_t;

  // Shadow slot table
  status_t               slot_state [NUM_TASKS];
  logic [TIME_WIDTH-1:0] job_len    [NUM_TASKS];
  logic [TIME_WIDTH-1:0] job_period [NUM_TASKS];
  logic [TIME_WIDTH-1:0] work_left  [NUM_TASKS];
  logic [TIME_WIDTH-1:0] countdown  [NUM_TASKS];
  logic [TIME_WIDTH-1:0] releases   [NUM_TASKS];
  int                    running_slot;
  logic [CNT_W-1:0]      tick_total;
  logic [CNT_W-1:0]      idle_total;

  dispatch_result_t expected_q[$];
  int mismatches;

  assign fail_count = mismatches;

  task automatic release_job(input int s);
    slot_state[s] = ST_READY;
    work_left[s]  = job_len[s];
    countdown[s]  = job_period[s];
    releases[s]   = releases[s] + 1'b1;
  endtask

  task automatic dispatch_step(input opcode_t op, input int s,
                               input logic [TIME_WIDTH-1:0] len,
                               input logic [TIME_WIDTH-1:0] per,
                               input logic [TIME_WIDTH-1:0] offs,
                               output dispatch_result_t r);
    int  pick;
    bit  found;
    r.start_ev  = 1'b0;
    r.start_job = '0;
    r.fin_ev    = 1'b0;
    r.fin_task  = '0;
    r.fin_job   = '0;
    if (op == OP_CREATE) begin
      job_len[s]    = len;
      job_period[s] = per;
      releases[s]   = '0;
      if (offs == '0) begin
        release_job(s);
      end else begin
        slot_state[s] = ST_WAITING;
        countdown[s]  = offs;
        work_left[s]  = '0;
      end
    end else begin
      tick_total = tick_total + 1'b1;
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (slot_state[i] != ST_DELETED) begin
          countdown[i] = countdown[i] - 1'b1;
          if (countdown[i] == '0) release_job(i);
        end
      end
      // drop a running job that has no work left before selection
      if (running_slot < NUM_TASKS && work_left[running_slot] == '0)
        running_slot = NUM_TASKS;

      pick  = NUM_TASKS;
      found = 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (!found && (slot_state[i] == ST_READY || slot_state[i] == ST_PENDING)) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        for (int i = pick + 1; i < NUM_TASKS; i++) begin
          if (slot_state[i] == ST_READY) slot_state[i] = ST_PENDING;
        end
        if (pick != running_slot && work_left[pick] == job_len[pick]) begin
          r.start_ev  = 1'b1;
          r.start_job = releases[pick];
        end
        slot_state[pick] = ST_READY;
      end
      running_slot = pick;

      if (running_slot < NUM_TASKS) begin
        work_left[running_slot] = work_left[running_slot] - 1'b1;
        if (work_left[running_slot] == '0) begin
          slot_state[running_slot] = ST_WAITING;
          r.fin_ev   = 1'b1;
          r.fin_task = SLOT_W'(running_slot);
          r.fin_job  = releases[running_slot];
        end
      end else begin
        idle_total = idle_total + 1'b1;
      end
    end
    r.running = RUN_W'(running_slot);
    r.ticks   = tick_total;
    r.idles   = idle_total;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    mismatches      = 0;
    results_seen    = 0;
    starts_seen     = 0;
    finishes_seen   = 0;
    waiting_results = 0;
  end

  always @(posedge clk) begin : watch
    dispatch_result_t oldest;
    dispatch_result_t fresh;
    if (rst) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        slot_state[i] = ST_DELETED;
        work_left[i]  = '0;
        countdown[i]  = '0;
        releases[i]   = '0;
        job_len[i]    = '0;
        job_period[i] = '0;
      end
      running_slot = NUM_TASKS;
      tick_total   = '0;
      idle_total   = '0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (start_event)  starts_seen++;
        if (finish_event) finishes_seen++;
        if (expected_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          oldest = expected_q.pop_front();
          check_field("running_task", oldest.running,   running_task);
          check_field("start_event",  oldest.start_ev,  start_event);
          check_field("start_job",    oldest.start_job, start_job);
          check_field("finish_event", oldest.fin_ev,    finish_event);
          check_field("finish_task",  oldest.fin_task,  finish_task);
          check_field("finish_job",   oldest.fin_job,   finish_job);
          check_field("tick_time",    oldest.ticks,     tick_time);
          check_field("idle_ticks",   oldest.idles,     idle_ticks);
        end
      end
      if (in_valid && !in_stall) begin
        dispatch_step(opcode, int'(task_slot), exec_time, release_period,
                      first_offset, fresh);
        expected_q.push_back(fresh);
      end
    end
    waiting_results <= expected_q.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the task dispatcher with a directed opening of creates and ticks,
// then a long random mix, with random gaps on both channels and one long
// output hold-off. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import fptd_pkg::*;

  localparam int NUM_TASKS  = 8;
  localparam int TIME_WIDTH = 16;
  localparam int SLOT_W     = $clog2(NUM_TASKS);
  localparam int RUN_W      = $clog2(NUM_TASKS + 1);
  localparam int RANDOM_REQUESTS = 825;
  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 300;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  opcode_t               opcode;
  logic [SLOT_W-1:0]     task_slot;
  logic [TIME_WIDTH-1:0] exec_time;
  logic [TIME_WIDTH-1:0] release_period;
  logic [TIME_WIDTH-1:0] first_offset;
  logic                  out_valid;
  logic                  out_stall;
  logic [RUN_W-1:0]      running_task;
  logic                  start_event;
  logic [TIME_WIDTH-1:0] start_job;
  logic                  finish_event;
  logic [SLOT_W-1:0]     finish_task;
  logic [TIME_WIDTH-1:0] finish_job;
  logic [CNT_W-1:0]      tick_time;
  logic [CNT_W-1:0]      idle_ticks;

  int fail_count;
  int waiting_results;
  int results_seen;
  int starts_seen;
  int finishes_seen;
  int requests_sent = 0;
  int ticks_sent    = 0;
  int creates_sent  = 0;
  int quiet_cycles  = 0;
  bit steady        = 1'b0;
  bit held_off      = 1'b0;

  always #5 clk = ~clk;

  fixed_priority_task_dispatcher #(
    .NUM_TASKS  (NUM_TASKS),
    .TIME_WIDTH (TIME_WIDTH)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .task_slot      (task_slot),
    .exec_time      (exec_time),
    .release_period (release_period),
    .first_offset   (first_offset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .running_task   (running_task),
    .start_event    (start_event),
    .start_job      (start_job),
    .finish_event   (finish_event),
    .finish_task    (finish_task),
    .finish_job     (finish_job),
    .tick_time      (tick_time),
    .idle_ticks     (idle_ticks)
  );

  fptd_dispatch_checker #(
    .NUM_TASKS  (NUM_TASKS),
    .TIME_WIDTH (TIME_WIDTH)
  ) i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .task_slot       (task_slot),
    .exec_time       (exec_time),
    .release_period  (release_period),
    .first_offset    (first_offset),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .running_task    (running_task),
    .start_event     (start_event),
    .start_job       (start_job),
    .finish_event    (finish_event),
    .finish_task     (finish_task),
    .finish_job      (finish_job),
    .tick_time       (tick_time),
    .idle_ticks      (idle_ticks),
    .fail_count      (fail_count),
    .waiting_results (waiting_results),
    .results_seen    (results_seen),
    .starts_seen     (starts_seen),
    .finishes_seen   (finishes_seen)
  );

  // Offer one request, with an occasional random gap ahead of it, and hold it
  // until the block takes it.
  task automatic send_request(input opcode_t op, input logic [SLOT_W-1:0] s,
                              input logic [TIME_WIDTH-1:0] len,
                              input logic [TIME_WIDTH-1:0] per,
                              input logic [TIME_WIDTH-1:0] offs);
    if (!steady && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    opcode         <= op;
    task_slot      <= s;
    exec_time      <= len;
    release_period <= per;
    first_offset   <= offs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    if (op == OP_TICK) ticks_sent++;
    else creates_sent++;
  endtask

  // Tick payload fields are don't-care; fill them with noise.
  task automatic send_tick();
    send_request(OP_TICK, SLOT_W'($urandom), TIME_WIDTH'($urandom),
                 TIME_WIDTH'($urandom), TIME_WIDTH'($urandom));
  endtask

  // Mostly short spans so jobs release and finish often, now and then a long one.
  function automatic logic [TIME_WIDTH-1:0] draw_span(input int lo, input int short_hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return TIME_WIDTH'($urandom_range(short_hi, lo));
    if (r < 95) return TIME_WIDTH'($urandom_range(4 * short_hi, short_hi + 1));
    return TIME_WIDTH'($urandom_range(65535, lo));
  endfunction

  // Stimulus
  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    opcode         <= OP_TICK;
    task_slot      <= '0;
    exec_time      <= '0;
    release_period <= '0;
    first_offset   <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening
    send_tick();
    send_request(OP_CREATE, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(OP_CREATE, 3'd5, 16'd3, 16'd8, 16'd0);
    send_tick();
    send_request(OP_CREATE, 3'd1, 16'd2, 16'd4, 16'd1);
    repeat (5) send_tick();
    // period one: re-released every tick while still current
    send_request(OP_CREATE, 3'd0, 16'd1, 16'd1, 16'd0);
    repeat (3) send_tick();
    send_request(OP_CREATE, 3'd5, 16'd4, 16'd7, 16'd2);
    send_request(OP_CREATE, 3'd0, 16'd2, 16'd5, 16'd3);
    // zero length and zero period wrap through the full counter range
    send_request(OP_CREATE, 3'd6, 16'd0, 16'd0, 16'd0);
    repeat (4) send_tick();
    send_request(OP_CREATE, 3'd6, 16'd2, 16'd3, 16'd0);
    repeat (3) send_tick();

    // Random mix
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      steady = (n >= 400 && n < 550);
      if ($urandom_range(0, 99) < 25) begin
        send_request(OP_CREATE, SLOT_W'($urandom_range(NUM_TASKS - 1, 0)),
                     draw_span(1, 5), draw_span(1, 16),
                     ($urandom_range(0, 99) < 40) ? '0 : draw_span(1, 10));
      end else begin
        send_tick();
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (waiting_results != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d requests (%0d ticks, %0d creates), %0d results checked,",
             requests_sent, ticks_sent, creates_sent, results_seen);
    $display("  with %0d job starts and %0d job completions observed.",
             starts_seen, finishes_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off that backs the block up.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && requests_sent >= 300) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !steady && ($urandom_range(0, 99) < 21);
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

[fixed_priority_task_dispatcher.f]
rtl/core/fptd_pkg.sv
rtl/core/fptd_ram.sv
rtl/core/fixed_priority_task_dispatcher.sv
tb/fptd_dispatch_checker.sv
tb/tb.sv
